// ===== src/pam_pkg.sv =====
// Shared definitions for the priority address range map.
// Holds default sizes, request and status codes, and the cell control struct.
// No dependencies.
package pam_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int ADDR_BITS_DEF   = 16;
    localparam int DEVICE_BITS_DEF = 4;
    localparam int HANDLE_BITS_DEF = 8;

    localparam int REQ_BITS    = 2;
    localparam int STATUS_BITS = 2;

    localparam logic [REQ_BITS-1:0] REQ_LOOKUP = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_ADD    = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_REMOVE = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_NO_HANDLE = 2'd2;

    typedef struct packed {
        logic match_en;  // evaluate the cell's own match for a new transaction
        logic lookup;    // match on address range
        logic remove;    // match on handle
        logic scan_en;   // advance the priority wave one cell
        logic push_en;   // take the entry in front, new entry enters cell 0
        logic pull_en;   // close the gap behind the removed entry
    } t_cell_ctl;

endpackage

// ===== src/pam_cell.sv =====
// One slot of the mapping chain: entry storage, local match and one stage of
// the priority wave. Depends on pam_pkg.
module pam_cell #(
    parameter int ADDR_BITS   = 16,
    parameter int DEVICE_BITS = 4,
    parameter int HANDLE_BITS = 8,
    parameter int CNT_BITS    = 5,
    parameter int INDEX       = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  pam_pkg::t_cell_ctl     i_ctl,
    input  logic [CNT_BITS-1:0]    i_total,
    input  logic [ADDR_BITS-1:0]   i_address,
    input  logic [HANDLE_BITS-1:0] i_handle,
    input  logic [ADDR_BITS-1:0]   i_prev_first,
    input  logic [ADDR_BITS-1:0]   i_prev_last,
    input  logic [DEVICE_BITS-1:0] i_prev_dev,
    input  logic [HANDLE_BITS-1:0] i_prev_id,
    input  logic [ADDR_BITS-1:0]   i_next_first,
    input  logic [ADDR_BITS-1:0]   i_next_last,
    input  logic [DEVICE_BITS-1:0] i_next_dev,
    input  logic [HANDLE_BITS-1:0] i_next_id,
    input  logic                   i_cfound,
    input  logic [DEVICE_BITS-1:0] i_cdev,
    input  logic [HANDLE_BITS-1:0] i_cid,
    output logic [ADDR_BITS-1:0]   o_first,
    output logic [ADDR_BITS-1:0]   o_last,
    output logic [DEVICE_BITS-1:0] o_dev,
    output logic [HANDLE_BITS-1:0] o_id,
    output logic                   o_cfound,
    output logic [DEVICE_BITS-1:0] o_cdev,
    output logic [HANDLE_BITS-1:0] o_cid
);
    import pam_pkg::*;

    logic [ADDR_BITS-1:0]   r_first;
    logic [ADDR_BITS-1:0]   r_last;
    logic [DEVICE_BITS-1:0] r_dev;
    logic [HANDLE_BITS-1:0] r_id;
    logic                   r_match;
    logic                   r_cfound;
    logic [DEVICE_BITS-1:0] r_cdev;
    logic [HANDLE_BITS-1:0] r_cid;
    logic                   w_used;
    logic                   w_in_range;
    logic                   n_match;

    assign w_used     = CNT_BITS'(INDEX) < i_total;
    assign w_in_range = (r_first <= i_address) && (i_address <= r_last);
    assign n_match    = w_used && ((i_ctl.lookup && w_in_range) ||
                                   (i_ctl.remove && (r_id == i_handle)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match  <= 1'b0;
            r_cfound <= 1'b0;
        end else if (i_ctl.match_en) begin
            r_match  <= n_match;
            r_cfound <= 1'b0;
        end else if (i_ctl.scan_en) begin
            r_cfound <= i_cfound | r_match;
        end
    end

    // Pass on the frontmost hit seen so far, else offer this slot's own.
    always_ff @(posedge i_clk) begin
        if (i_ctl.scan_en) begin
            if (i_cfound) begin
                r_cdev <= i_cdev;
                r_cid  <= i_cid;
            end else begin
                r_cdev <= r_dev;
                r_cid  <= r_id;
            end
        end
    end

    // Slots at or behind the removed one hold a settled wave flag: pull.
    always_ff @(posedge i_clk) begin
        if (i_ctl.push_en) begin
            r_first <= i_prev_first;
            r_last  <= i_prev_last;
            r_dev   <= i_prev_dev;
            r_id    <= i_prev_id;
        end else if (i_ctl.pull_en && r_cfound) begin
            r_first <= i_next_first;
            r_last  <= i_next_last;
            r_dev   <= i_next_dev;
            r_id    <= i_next_id;
        end
    end

    assign o_first  = r_first;
    assign o_last   = r_last;
    assign o_dev    = r_dev;
    assign o_id     = r_id;
    assign o_cfound = r_cfound;
    assign o_cdev   = r_cdev;
    assign o_cid    = r_cid;

endmodule

// ===== src/priority_address_range_map.sv =====
// Priority address range map: top level with the cell chain and control FSM.
// Depends on pam_pkg and pam_cell.
//
// The block keeps up to MAX_ENTRIES address-range mappings in a chain of
// cells, slot 0 having the highest priority. Each request transaction gives
// exactly one result transaction. An add pushes the new mapping into slot 0
// and moves every slot back one place; a full table leaves it unchanged and
// reports status 1. A lookup or remove first lets every cell compare against
// the request in the accept cycle, then a priority wave runs down the chain,
// one cell per cycle, carrying the frontmost hit. Once the wave has passed
// every cell, the end of the chain holds the winning device and handle; on a
// remove the winner and the cells behind it pull from their neighbor to close
// the gap, and an absent handle reports status 2. An add or an unused request
// type skips the wave. One transaction is in flight at a time; a new one is
// accepted in the cycle after the previous result is registered, even while
// that result still waits on the output handshake. Entry contents have no
// reset; the fill count, the control state and the cells' match flags are cleared.
module priority_address_range_map #(
    parameter int MAX_ENTRIES = pam_pkg::MAX_ENTRIES_DEF,
    parameter int ADDR_BITS   = pam_pkg::ADDR_BITS_DEF,
    parameter int DEVICE_BITS = pam_pkg::DEVICE_BITS_DEF,
    parameter int HANDLE_BITS = pam_pkg::HANDLE_BITS_DEF,
    localparam int CNT_BITS   = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [pam_pkg::REQ_BITS-1:0]    i_req_type,
    input  logic [ADDR_BITS-1:0]            i_address,
    input  logic [ADDR_BITS-1:0]            i_range_start,
    input  logic [ADDR_BITS-1:0]            i_range_end,
    input  logic [DEVICE_BITS-1:0]          i_target_device,
    input  logic [HANDLE_BITS-1:0]          i_mapping_handle,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_hit,
    output logic [DEVICE_BITS-1:0]          o_found_device,
    output logic [HANDLE_BITS-1:0]          o_found_handle,
    output logic [pam_pkg::STATUS_BITS-1:0] o_status,
    output logic [CNT_BITS-1:0]             o_entries_used
);
    import pam_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    // Control state
    logic [1:0]             r_state;
    logic [1:0]             n_state;
    logic [CNT_BITS-1:0]    r_scan;
    logic [CNT_BITS-1:0]    r_total;
    logic [CNT_BITS-1:0]    n_total;
    logic                   r_out_valid;

    // Held request
    logic [REQ_BITS-1:0]    r_req;
    logic [ADDR_BITS-1:0]   r_req_first;
    logic [ADDR_BITS-1:0]   r_req_last;
    logic [DEVICE_BITS-1:0] r_req_dev;
    logic [HANDLE_BITS-1:0] r_req_id;

    // Result register
    logic                   r_hit;
    logic [DEVICE_BITS-1:0] r_fdev;
    logic [HANDLE_BITS-1:0] r_fid;
    logic [STATUS_BITS-1:0] r_status;
    logic [CNT_BITS-1:0]    r_used;
    logic                   n_hit;
    logic [DEVICE_BITS-1:0] n_fdev;
    logic [HANDLE_BITS-1:0] n_fid;
    logic [STATUS_BITS-1:0] n_status;

    logic                   w_accept;
    logic                   w_deliver;
    logic                   w_full;
    logic                   w_found;
    t_cell_ctl              w_ctl;

    // Chain wiring
    logic [ADDR_BITS-1:0]   w_first  [MAX_ENTRIES];
    logic [ADDR_BITS-1:0]   w_last   [MAX_ENTRIES];
    logic [DEVICE_BITS-1:0] w_dev    [MAX_ENTRIES];
    logic [HANDLE_BITS-1:0] w_id     [MAX_ENTRIES];
    logic                   w_cfound [MAX_ENTRIES+1];
    logic [DEVICE_BITS-1:0] w_cdev   [MAX_ENTRIES+1];
    logic [HANDLE_BITS-1:0] w_cid    [MAX_ENTRIES+1];

    assign o_ready   = (r_state == S_IDLE);
    assign w_accept  = i_valid && o_ready;
    assign w_deliver = (r_state == S_DONE) && (!r_out_valid || i_ready);
    assign w_full    = (r_total == CNT_BITS'(MAX_ENTRIES));
    assign w_found   = w_cfound[MAX_ENTRIES];

    // Head of the wave: nothing found ahead of slot 0.
    assign w_cfound[0] = 1'b0;
    assign w_cdev[0]   = '0;
    assign w_cid[0]    = '0;

    always_comb begin
        w_ctl          = '0;
        w_ctl.match_en = w_accept;
        w_ctl.lookup   = (i_req_type == REQ_LOOKUP);
        w_ctl.remove   = (i_req_type == REQ_REMOVE);
        w_ctl.scan_en  = (r_state == S_SCAN);
        w_ctl.push_en  = w_deliver && (r_req == REQ_ADD) && !w_full;
        w_ctl.pull_en  = w_deliver && (r_req == REQ_REMOVE) && w_found;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
            logic [ADDR_BITS-1:0]   w_pf;
            logic [ADDR_BITS-1:0]   w_pl;
            logic [DEVICE_BITS-1:0] w_pd;
            logic [HANDLE_BITS-1:0] w_pi;
            logic [ADDR_BITS-1:0]   w_nf;
            logic [ADDR_BITS-1:0]   w_nl;
            logic [DEVICE_BITS-1:0] w_nd;
            logic [HANDLE_BITS-1:0] w_ni;

            // The new mapping enters at the front of the chain.
            if (g == 0) begin : g_front
                assign w_pf = r_req_first;
                assign w_pl = r_req_last;
                assign w_pd = r_req_dev;
                assign w_pi = r_req_id;
            end else begin : g_mid
                assign w_pf = w_first[g-1];
                assign w_pl = w_last[g-1];
                assign w_pd = w_dev[g-1];
                assign w_pi = w_id[g-1];
            end

            // The last slot has nothing behind it; what it pulls is never read.
            if (g == MAX_ENTRIES - 1) begin : g_back
                assign w_nf = '0;
                assign w_nl = '0;
                assign w_nd = '0;
                assign w_ni = '0;
            end else begin : g_inner
                assign w_nf = w_first[g+1];
                assign w_nl = w_last[g+1];
                assign w_nd = w_dev[g+1];
                assign w_ni = w_id[g+1];
            end

            pam_cell #(
                .ADDR_BITS   (ADDR_BITS),
                .DEVICE_BITS (DEVICE_BITS),
                .HANDLE_BITS (HANDLE_BITS),
                .CNT_BITS    (CNT_BITS),
                .INDEX       (g)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_total      (r_total),
                .i_address    (i_address),
                .i_handle     (i_mapping_handle),
                .i_prev_first (w_pf),
                .i_prev_last  (w_pl),
                .i_prev_dev   (w_pd),
                .i_prev_id    (w_pi),
                .i_next_first (w_nf),
                .i_next_last  (w_nl),
                .i_next_dev   (w_nd),
                .i_next_id    (w_ni),
                .i_cfound     (w_cfound[g]),
                .i_cdev       (w_cdev[g]),
                .i_cid        (w_cid[g]),
                .o_first      (w_first[g]),
                .o_last       (w_last[g]),
                .o_dev        (w_dev[g]),
                .o_id         (w_id[g]),
                .o_cfound     (w_cfound[g+1]),
                .o_cdev       (w_cdev[g+1]),
                .o_cid        (w_cid[g+1])
            );
        end
    endgenerate

    // Sequencer: accept, run the wave when the request needs a search, deliver.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req_type == REQ_LOOKUP || i_req_type == REQ_REMOVE) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (r_scan == CNT_BITS'(MAX_ENTRIES - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_deliver) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_scan  <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_scan <= '0;
            end else if (r_state == S_SCAN) begin
                r_scan <= r_scan + 1'b1;
            end
        end
    end

    // Hold the request fields that the add needs at delivery.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req       <= i_req_type;
            r_req_first <= i_range_start;
            r_req_last  <= i_range_end;
            r_req_dev   <= i_target_device;
            r_req_id    <= i_mapping_handle;
        end
    end

    // Form the result from the settled wave and the fill count.
    always_comb begin
        n_hit    = 1'b0;
        n_fdev   = '0;
        n_fid    = '0;
        n_status = ST_OK;
        n_total  = r_total;
        case (r_req)
            REQ_LOOKUP: begin
                n_hit = w_found;
                if (w_found) begin
                    n_fdev = w_cdev[MAX_ENTRIES];
                    n_fid  = w_cid[MAX_ENTRIES];
                end
            end
            REQ_ADD: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_total = r_total + 1'b1;
                end
            end
            REQ_REMOVE: begin
                if (w_found) begin
                    n_total = r_total - 1'b1;
                end else begin
                    n_status = ST_NO_HANDLE;
                end
            end
            default: n_status = ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_deliver) begin
                r_total     <= n_total;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_deliver) begin
            r_hit    <= n_hit;
            r_fdev   <= n_fdev;
            r_fid    <= n_fid;
            r_status <= n_status;
            r_used   <= n_total;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_hit          = r_hit;
    assign o_found_device = r_fdev;
    assign o_found_handle = r_fid;
    assign o_status       = r_status;
    assign o_entries_used = r_used;

endmodule

// ===== src/pam_checker.sv =====
// Port-level checks for the priority address range map, bound to the top level.
// Depends on pam_pkg and priority_address_range_map.
module pam_checker #(
    parameter int MAX_ENTRIES = pam_pkg::MAX_ENTRIES_DEF,
    parameter int ADDR_BITS   = pam_pkg::ADDR_BITS_DEF,
    parameter int DEVICE_BITS = pam_pkg::DEVICE_BITS_DEF,
    parameter int HANDLE_BITS = pam_pkg::HANDLE_BITS_DEF,
    localparam int CNT_BITS   = $clog2(MAX_ENTRIES + 1)
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_ready,
    input logic [pam_pkg::REQ_BITS-1:0]    i_req_type,
    input logic [ADDR_BITS-1:0]            i_address,
    input logic [ADDR_BITS-1:0]            i_range_start,
    input logic [ADDR_BITS-1:0]            i_range_end,
    input logic [DEVICE_BITS-1:0]          i_target_device,
    input logic [HANDLE_BITS-1:0]          i_mapping_handle,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic                            o_hit,
    input logic [DEVICE_BITS-1:0]          o_found_device,
    input logic [HANDLE_BITS-1:0]          o_found_handle,
    input logic [pam_pkg::STATUS_BITS-1:0] o_status,
    input logic [CNT_BITS-1:0]             o_entries_used
);
    import pam_pkg::*;

    // Fill count never goes past the table size.
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_entries_used <= CNT_BITS'(MAX_ENTRIES)))
        else $error("entries_used above table size");

    // A hit only comes from a lookup, which always reports ok.
    a_hit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> (o_status == ST_OK))
        else $error("hit with non-ok status");

    // A miss carries no device or handle.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_found_device == '0 && o_found_handle == '0))
        else $error("miss with nonzero device or handle");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_hit) && $stable(o_status) &&
                                   $stable(o_entries_used) && $stable(o_found_handle)))
        else $error("result changed while stalled");

endmodule

bind priority_address_range_map pam_checker #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .ADDR_BITS   (ADDR_BITS),
    .DEVICE_BITS (DEVICE_BITS),
    .HANDLE_BITS (HANDLE_BITS)
) u_pam_checker (.*);
